FILE: rtl/core/mcsdb_pkg.sv
// Shared types and constants for the multicore semaphore and doorbell register block.
// No dependencies; the controller, datapath and top level import it.
`default_nettype none

package mcsdb_pkg;

  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned NUM_SEMA = 32;
  localparam int unsigned NUM_MBOX = 8;
  localparam int unsigned NUM_VPU_SEMA = 2;
  localparam int unsigned NUM_DOORBELL = 2;
  localparam int unsigned NUM_IREQ = 2;

  // Word indexes, taken from the byte offsets of the register window
  localparam logic [ADDR_W-1:0] WORD_SEMA_LAST  = ADDR_W'(12'h07c >> 2);
  localparam logic [ADDR_W-1:0] WORD_STATUS     = ADDR_W'(12'h080 >> 2);
  localparam logic [ADDR_W-1:0] WORD_IREQ_0     = ADDR_W'(12'h084 >> 2);
  localparam logic [ADDR_W-1:0] WORD_IREQ_1     = ADDR_W'(12'h088 >> 2);
  localparam logic [ADDR_W-1:0] WORD_ICSET_0    = ADDR_W'(12'h090 >> 2);
  localparam logic [ADDR_W-1:0] WORD_ICCLR_0    = ADDR_W'(12'h098 >> 2);
  localparam logic [ADDR_W-1:0] WORD_MBOX_FIRST = ADDR_W'(12'h0a0 >> 2);
  localparam logic [ADDR_W-1:0] WORD_MBOX_LAST  = ADDR_W'(12'h0bc >> 2);
  localparam logic [ADDR_W-1:0] WORD_VPUSEMA_0  = ADDR_W'(12'h0c0 >> 2);
  localparam logic [ADDR_W-1:0] WORD_VPU_STAT   = ADDR_W'(12'h0c8 >> 2);

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } bus_cmd_t;

  typedef enum logic [1:0] {
    ACC_OK       = 2'd0,
    ACC_READONLY = 2'd1,
    ACC_UNMAPPED = 2'd2
  } acc_status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // perform the access and load the result register
  } ctl_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/mcsdb_ctrl.sv
// Controller state machine: input handshake, execute sequencing, result valid.
// Depends on mcsdb_pkg; drives commands into mcsdb_datapath.
`default_nettype none

module mcsdb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mcsdb_pkg::ctl_cmd_t    ctl_cmd
);
  import mcsdb_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // The result register may be reloaded when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    ctl_cmd.load = 1'b0;
    ctl_cmd.exec = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall     = 1'b0;
        ctl_cmd.load = in_valid;
      end
      ST_EXEC: begin
        ctl_cmd.exec = out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl_cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.load |=> state_r == ST_EXEC)
    else $error("accepted item did not move the controller to execute");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.exec |=> out_valid_r)
    else $error("executed item produced no valid result");

  a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("stalled result dropped");

  a_no_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EXEC |-> !ctl_cmd.load && in_stall)
    else $error("item accepted while another is in execution");

endmodule

`default_nettype wire

FILE: rtl/core/mcsdb_datapath.sv
// Datapath: captured item, semaphore/mask/doorbell/mailbox state and result register.
// Depends on mcsdb_pkg; sequenced by mcsdb_ctrl through ctl_cmd_t.
`default_nettype none

module mcsdb_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mcsdb_pkg::ctl_cmd_t          ctl_cmd,
  input  wire logic                         in_cmd,
  input  wire logic [mcsdb_pkg::ADDR_W-1:0] in_word_addr,
  input  wire logic [mcsdb_pkg::DATA_W-1:0] in_write_data,
  output logic [mcsdb_pkg::DATA_W-1:0]      out_read_data,
  output logic [1:0]                        out_access_status,
  output logic                              out_irq_sema_0,
  output logic                              out_irq_sema_1,
  output logic                              out_irq_core_0,
  output logic                              out_irq_core_1
);
  import mcsdb_pkg::*;

  // Captured item
  logic              wr_r;
  logic [ADDR_W-1:0] addr_r;
  logic [DATA_W-1:0] wdata_r;

  // Architectural state
  logic [NUM_SEMA-1:0]     sema_r, sema_nxt;
  logic [DATA_W-1:0]       ireq_r [NUM_IREQ], ireq_nxt [NUM_IREQ];
  logic [NUM_DOORBELL-1:0] bell_r, bell_nxt;
  logic [DATA_W-1:0]       mbox_r [NUM_MBOX];
  logic [NUM_VPU_SEMA-1:0] vsema_r, vsema_nxt;
  logic                    mbox_we;

  // Result
  logic [DATA_W-1:0] rd_nxt, rd_r;
  acc_status_t       st_nxt, st_r;
  logic [3:0]        irq_nxt, irq_r;

  logic [ADDR_W-1:0] ireq_off, bell_off, mbox_off, vsema_off;
  logic              ireq_k, bell_k, vsema_k;
  logic [2:0]        mbox_k;
  logic [4:0]        sema_k;

  assign ireq_off  = addr_r - WORD_IREQ_0;
  assign bell_off  = addr_r - WORD_ICSET_0;
  assign mbox_off  = addr_r - WORD_MBOX_FIRST;
  assign vsema_off = addr_r - WORD_VPUSEMA_0;
  assign ireq_k    = ireq_off[0];
  assign bell_k    = bell_off[0];
  assign mbox_k    = mbox_off[2:0];
  assign vsema_k   = vsema_off[0];
  assign sema_k    = addr_r[4:0];

  always_ff @(posedge clk) begin
    if (ctl_cmd.load) begin
      wr_r    <= in_cmd;
      addr_r  <= in_word_addr;
      wdata_r <= in_write_data;
    end
  end

  always_comb begin
    sema_nxt  = sema_r;
    ireq_nxt  = ireq_r;
    bell_nxt  = bell_r;
    vsema_nxt = vsema_r;
    mbox_we   = 1'b0;
    rd_nxt    = '0;
    st_nxt    = ACC_OK;

    if (addr_r <= WORD_SEMA_LAST) begin
      if (wr_r == CMD_WRITE) begin
        sema_nxt[sema_k] = 1'b0;
      end else begin
        rd_nxt           = DATA_W'(sema_r[sema_k]);
        sema_nxt[sema_k] = 1'b1;
      end
    end else if (addr_r == WORD_STATUS || addr_r == WORD_VPU_STAT) begin
      if (wr_r == CMD_WRITE) begin
        st_nxt = ACC_READONLY;
      end else if (addr_r == WORD_STATUS) begin
        rd_nxt = sema_r;
      end
    end else if (addr_r == WORD_IREQ_0 || addr_r == WORD_IREQ_1) begin
      if (wr_r == CMD_WRITE) ireq_nxt[ireq_k] = wdata_r;
      else                   rd_nxt = ireq_r[ireq_k];
    end else if (addr_r >= WORD_ICSET_0 && addr_r <= WORD_ICCLR_0 + ADDR_W'(1)) begin
      if (wr_r == CMD_WRITE) begin
        // Set word when below the clear words; only data bit 0 acts
        if (wdata_r[0]) bell_nxt[bell_k] = (addr_r < WORD_ICCLR_0);
      end else begin
        rd_nxt = DATA_W'(bell_r[bell_k]);
      end
    end else if (addr_r >= WORD_MBOX_FIRST && addr_r <= WORD_MBOX_LAST) begin
      if (wr_r == CMD_WRITE) mbox_we = 1'b1;
      else                   rd_nxt = mbox_r[mbox_k];
    end else if (addr_r == WORD_VPUSEMA_0 || addr_r == WORD_VPUSEMA_0 + ADDR_W'(1)) begin
      if (wr_r == CMD_WRITE) begin
        vsema_nxt[vsema_k] = 1'b0;
      end else begin
        rd_nxt             = DATA_W'(vsema_r[vsema_k]);
        vsema_nxt[vsema_k] = 1'b1;
      end
    end else begin
      st_nxt = ACC_UNMAPPED;
    end

    if (wr_r == CMD_WRITE) rd_nxt = '0;

    // Interrupt levels reflect the state after this access
    irq_nxt[0] = |(ireq_nxt[0] & ~sema_nxt);
    irq_nxt[1] = |(ireq_nxt[1] & ~sema_nxt);
    irq_nxt[2] = bell_nxt[0];
    irq_nxt[3] = bell_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sema_r  <= '0;
      ireq_r  <= '{default: '0};
      bell_r  <= '0;
      mbox_r  <= '{default: '0};
      vsema_r <= '0;
    end else if (ctl_cmd.exec) begin
      sema_r  <= sema_nxt;
      ireq_r  <= ireq_nxt;
      bell_r  <= bell_nxt;
      vsema_r <= vsema_nxt;
      if (mbox_we) mbox_r[mbox_k] <= wdata_r;
    end
  end

  // Result register; levels start low after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_r <= '0;
    end else if (ctl_cmd.exec) begin
      irq_r <= irq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_cmd.exec) begin
      rd_r <= rd_nxt;
      st_r <= st_nxt;
    end
  end

  assign out_read_data     = rd_r;
  assign out_access_status = st_r;
  assign out_irq_sema_0    = irq_r[0];
  assign out_irq_sema_1    = irq_r[1];
  assign out_irq_core_0    = irq_r[2];
  assign out_irq_core_1    = irq_r[3];

  a_claim_sets_bit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.exec && wr_r == CMD_READ && addr_r <= WORD_SEMA_LAST |=> sema_r[$past(sema_k)])
    else $error("semaphore read did not claim the semaphore");

  a_write_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.exec && wr_r == CMD_WRITE |=> rd_r == '0)
    else $error("write returned nonzero read data");

  a_no_exec_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_cmd.exec |=> $stable(sema_r) && $stable(bell_r) && $stable(vsema_r))
    else $error("state changed without an executed item");

endmodule

`default_nettype wire

FILE: rtl/core/multicore_semaphore_doorbell_regs.sv
// Multicore semaphore and doorbell register block: one bus access per item.
// The accepted item is captured, then executed into the result register once that register is free.
// The controller takes no new item until the current one has executed (capture, then execute).
// The next item is accepted while a finished result still waits on out_stall.
// Reset (synchronous, rst_n low): all semaphores free, masks, doorbells and mailboxes zero.
`default_nettype none

module multicore_semaphore_doorbell_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [mcsdb_pkg::ADDR_W-1:0] in_word_addr,
  input  wire logic [mcsdb_pkg::DATA_W-1:0] in_write_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mcsdb_pkg::DATA_W-1:0]      out_read_data,
  output logic [1:0]                        out_access_status,
  output logic                              out_irq_sema_0,
  output logic                              out_irq_sema_1,
  output logic                              out_irq_core_0,
  output logic                              out_irq_core_1
);
  import mcsdb_pkg::*;

  ctl_cmd_t ctl_cmd;

  mcsdb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl_cmd   (ctl_cmd)
  );

  mcsdb_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl_cmd           (ctl_cmd),
    .in_cmd            (in_cmd),
    .in_word_addr      (in_word_addr),
    .in_write_data     (in_write_data),
    .out_read_data     (out_read_data),
    .out_access_status (out_access_status),
    .out_irq_sema_0    (out_irq_sema_0),
    .out_irq_sema_1    (out_irq_sema_1),
    .out_irq_core_0    (out_irq_core_0),
    .out_irq_core_1    (out_irq_core_1)
  );

endmodule

`default_nettype wire

FILE: dv/tb_multicore_semaphore_doorbell_regs.sv
// Self-checking bench for the multicore semaphore and doorbell register block.
// Depends on mcsdb_pkg and the block's top level; a scoreboard class predicts
// every result and plain tasks drive random and directed bus accesses.
`timescale 1ns / 100ps

module tb_multicore_semaphore_doorbell_regs;
  import mcsdb_pkg::*;

  localparam int unsigned RANDOM_ACCESSES = 1850;
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [ADDR_W-1:0] WORD_SEMA_FIRST = '0;
  localparam logic [ADDR_W-1:0] WORD_ICSET_1 = WORD_ICSET_0 + 6'd1;
  localparam logic [ADDR_W-1:0] WORD_ICCLR_1 = WORD_ICCLR_0 + 6'd1;
  localparam logic [ADDR_W-1:0] WORD_VPUSEMA_1 = WORD_VPUSEMA_0 + 6'd1;
  localparam logic [ADDR_W-1:0] WORD_GAP = WORD_IREQ_1 + 6'd1;
  localparam logic [ADDR_W-1:0] WORD_TOP = '1;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    acc_status_t       status;
    logic              irq_sema_0;
    logic              irq_sema_1;
    logic              irq_core_0;
    logic              irq_core_1;
  } access_result_t;

  class doorbell_scoreboard;
    logic [31:0]    sema_bits;
    logic [31:0]    request_mask [NUM_IREQ];
    logic [1:0]     bell_pending;
    logic [31:0]    mailbox [NUM_MBOX];
    logic [1:0]     extra_sema_bits;
    access_result_t predicted_results [$];
    int unsigned    errors;
    int unsigned    reads;
    int unsigned    writes;
    int unsigned    checked;
    int unsigned    readonly_hits;
    int unsigned    unmapped_hits;

    function new();
      sema_bits = '0;
      bell_pending = '0;
      extra_sema_bits = '0;
      foreach (request_mask[i]) request_mask[i] = '0;
      foreach (mailbox[i]) mailbox[i] = '0;
      errors = 0;
      reads = 0;
      writes = 0;
      checked = 0;
      readonly_hits = 0;
      unmapped_hits = 0;
    endfunction

    function void note_access(bus_cmd_t cmd, logic [ADDR_W-1:0] addr, logic [31:0] wdata);
      access_result_t r;
      logic [ADDR_W-1:0] off;
      logic is_wr;
      is_wr = (cmd == CMD_WRITE);
      r = '0;
      r.status = ACC_OK;
      if (is_wr) writes++;
      else reads++;
      if (addr <= WORD_SEMA_LAST) begin
        if (is_wr) sema_bits[addr[4:0]] = 1'b0;
        else begin
          r.read_data = {31'b0, sema_bits[addr[4:0]]};
          sema_bits[addr[4:0]] = 1'b1;
        end
      end else if (addr == WORD_STATUS || addr == WORD_VPU_STAT) begin
        if (is_wr) r.status = ACC_READONLY;
        else if (addr == WORD_STATUS) r.read_data = sema_bits;
      end else if (addr == WORD_IREQ_0 || addr == WORD_IREQ_1) begin
        off = addr - WORD_IREQ_0;
        if (is_wr) request_mask[off[0]] = wdata;
        else r.read_data = request_mask[off[0]];
      end else if (addr >= WORD_ICSET_0 && addr <= WORD_ICCLR_1) begin
        off = addr - WORD_ICSET_0;
        if (!is_wr) r.read_data = {31'b0, bell_pending[off[0]]};
        else if (wdata[0]) bell_pending[off[0]] = (addr < WORD_ICCLR_0);
      end else if (addr >= WORD_MBOX_FIRST && addr <= WORD_MBOX_LAST) begin
        off = addr - WORD_MBOX_FIRST;
        if (is_wr) mailbox[off[2:0]] = wdata;
        else r.read_data = mailbox[off[2:0]];
      end else if (addr == WORD_VPUSEMA_0 || addr == WORD_VPUSEMA_1) begin
        off = addr - WORD_VPUSEMA_0;
        if (is_wr) extra_sema_bits[off[0]] = 1'b0;
        else begin
          r.read_data = {31'b0, extra_sema_bits[off[0]]};
          extra_sema_bits[off[0]] = 1'b1;
        end
      end else begin
        r.status = ACC_UNMAPPED;
      end
      if (r.status == ACC_READONLY) readonly_hits++;
      if (r.status == ACC_UNMAPPED) unmapped_hits++;
      // Interrupt levels reflect the state after the access
      r.irq_sema_0 = |(request_mask[0] & ~sema_bits);
      r.irq_sema_1 = |(request_mask[1] & ~sema_bits);
      r.irq_core_0 = bell_pending[0];
      r.irq_core_1 = bell_pending[1];
      predicted_results.push_back(r);
    endfunction

    function void check_result(access_result_t got);
      access_result_t exp;
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] unexpected result: data=%h status=%0d", $realtime,
                   got.read_data, got.status);
        return;
      end
      exp = predicted_results.pop_front();
      checked++;
      if (got !== exp) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] mismatch: data exp %h got %h, status exp %0d got %0d, irq exp %b%b%b%b got %b%b%b%b",
                   $realtime, exp.read_data, got.read_data, exp.status, got.status,
                   exp.irq_sema_0, exp.irq_sema_1, exp.irq_core_0, exp.irq_core_1,
                   got.irq_sema_0, got.irq_sema_1, got.irq_core_0, got.irq_core_1);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  bus_cmd_t          in_cmd = CMD_READ;
  logic [ADDR_W-1:0] in_word_addr = '0;
  logic [DATA_W-1:0] in_write_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [DATA_W-1:0] out_read_data;
  logic [1:0]        out_access_status;
  logic              out_irq_sema_0;
  logic              out_irq_sema_1;
  logic              out_irq_core_0;
  logic              out_irq_core_1;

  logic              idle_enable = 1'b1;
  int unsigned       hang_count = 0;
  doorbell_scoreboard sb = new();

  multicore_semaphore_doorbell_regs dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_word_addr      (in_word_addr),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_access_status (out_access_status),
    .out_irq_sema_0    (out_irq_sema_0),
    .out_irq_sema_1    (out_irq_sema_1),
    .out_irq_core_0    (out_irq_core_0),
    .out_irq_core_1    (out_irq_core_1)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= idle_enable && ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    access_result_t got;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      got.read_data = out_read_data;
      got.status = acc_status_t'(out_access_status);
      got.irq_sema_0 = out_irq_sema_0;
      got.irq_sema_1 = out_irq_sema_1;
      got.irq_core_0 = out_irq_core_0;
      got.irq_core_1 = out_irq_core_1;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        hang_count <= 0;
      else
        hang_count <= hang_count + 1;
      if (hang_count >= HANG_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", HANG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Hold the item until the block takes it; idle first at random
  task automatic send_access(input bus_cmd_t cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] wdata);
    while (idle_enable && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_word_addr <= addr;
    in_write_data <= wdata;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.note_access(cmd, addr, wdata);
  endtask

  task automatic random_access();
    bus_cmd_t          cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
    int unsigned       pick;
    cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
    wdata = $urandom();
    pick = $urandom_range(99);
    if (pick < 40) begin
      addr = ADDR_W'($urandom_range(WORD_SEMA_LAST, WORD_SEMA_FIRST));
    end else if (pick < 50) begin
      addr = $urandom_range(1) ? WORD_IREQ_1 : WORD_IREQ_0;
      // Sparse masks keep the semaphore interrupts toggling
      case ($urandom_range(2))
        0: wdata = 32'h1 << $urandom_range(31);
        1: wdata = wdata & $urandom() & $urandom();
        default: ;
      endcase
    end else if (pick < 65) begin
      addr = ADDR_W'($urandom_range(WORD_ICCLR_1, WORD_ICSET_0));
    end else if (pick < 80) begin
      addr = ADDR_W'($urandom_range(WORD_MBOX_LAST, WORD_MBOX_FIRST));
    end else if (pick < 88) begin
      addr = $urandom_range(1) ? WORD_VPUSEMA_1 : WORD_VPUSEMA_0;
    end else if (pick < 93) begin
      addr = $urandom_range(1) ? WORD_VPU_STAT : WORD_STATUS;
    end else begin
      addr = ($urandom_range(3) == 0) ? WORD_GAP
                                      : ADDR_W'($urandom_range(WORD_TOP, WORD_VPU_STAT + 1));
    end
    send_access(cmd, addr, wdata);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: claim and release, read-only and unmapped words, doorbells,
    // the first mailbox word and the extra semaphores
    send_access(CMD_READ,  WORD_SEMA_FIRST, 32'hffff_ffff);
    send_access(CMD_READ,  WORD_SEMA_FIRST, 32'h0);
    send_access(CMD_READ,  WORD_SEMA_LAST,  32'h0);
    send_access(CMD_WRITE, WORD_IREQ_0,     32'hffff_ffff);
    send_access(CMD_WRITE, WORD_IREQ_1,     32'h8000_0000);
    send_access(CMD_READ,  WORD_STATUS,     32'h0);
    send_access(CMD_WRITE, WORD_SEMA_LAST,  32'h0);
    send_access(CMD_WRITE, WORD_STATUS,     32'hffff_ffff);
    send_access(CMD_WRITE, WORD_VPU_STAT,   32'hffff_ffff);
    send_access(CMD_READ,  WORD_VPU_STAT,   32'h0);
    send_access(CMD_READ,  WORD_GAP,        32'h0);
    send_access(CMD_WRITE, WORD_GAP,        32'hffff_ffff);
    send_access(CMD_WRITE, WORD_TOP,        32'hffff_ffff);
    send_access(CMD_WRITE, WORD_ICSET_0,    32'h0000_0001);
    send_access(CMD_WRITE, WORD_ICSET_1,    32'hffff_fffe);
    send_access(CMD_READ,  WORD_ICSET_0,    32'h0);
    send_access(CMD_WRITE, WORD_ICSET_1,    32'hffff_ffff);
    send_access(CMD_WRITE, WORD_ICCLR_0,    32'hffff_fffe);
    send_access(CMD_READ,  WORD_ICCLR_1,    32'h0);
    send_access(CMD_WRITE, WORD_ICCLR_1,    32'h0000_0001);
    send_access(CMD_WRITE, WORD_MBOX_FIRST, 32'hffff_ffff);
    send_access(CMD_READ,  WORD_MBOX_FIRST, 32'h0);
    send_access(CMD_READ,  WORD_VPUSEMA_0,  32'h0);
    send_access(CMD_READ,  WORD_VPUSEMA_0,  32'h0);
    send_access(CMD_WRITE, WORD_VPUSEMA_0,  32'h0);

    for (int unsigned i = 0; i < RANDOM_ACCESSES; i++) begin
      // One long stretch with neither side idling
      if (i == 700) idle_enable <= 1'b0;
      if (i == 1100) idle_enable <= 1'b1;
      random_access();
    end
    in_valid <= 1'b0;

    while (sb.predicted_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.errors += sb.predicted_results.size();

    $display("Ran %0d accesses (%0d reads, %0d writes); %0d results checked, %0d mismatches",
             sb.reads + sb.writes, sb.reads, sb.writes, sb.checked, sb.errors);
    $display("Read-only writes: %0d, unmapped accesses: %0d",
             sb.readonly_hits, sb.unmapped_hits);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
